/* sv/clock_page_replacement_macros.svh */
// Assertion macros for the clock page replacement block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define CPR_ASSERT(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("cpr assertion failed");
// Implication checked at every clock edge outside reset.
`define CPR_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cpr implication failed");
`else
`define CPR_ASSERT(label, ck, rn, prop)
`define CPR_ASSERT_IMP(label, ck, rn, ante, cons)
`endif

`endif

/* sv/cpr_pkg.sv */
// Shared types and constants of the clock page replacement block.
// No dependencies; used by cpr_frame_store and clock_page_replacement.
package cpr_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int FRAMES_DEFAULT    = 16;
    localparam int PAGE_BITS_DEFAULT = 20;

    // Fixed field widths of the stream payloads.
    localparam int PAGE_W        = 20;
    localparam int FRAME_INDEX_W = 4;
    localparam int COUNT_W       = 32;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_USED_W    = 2 + PAGE_W + FRAME_INDEX_W + 2 * COUNT_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // Configuration register file.
    localparam int FRAME_COUNT_W = 5;
    localparam int TICK_PERIOD_W = 16;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [0:0] {
        REG_FRAME_COUNT = 1'b0,
        REG_TICK_PERIOD = 1'b1
    } cfg_reg_t;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 5'd16;
    localparam logic [TICK_PERIOD_W-1:0] TICK_PERIOD_RESET = 16'd8;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ADVANCE,
        ST_VICTIM,
        ST_FINISH
    } state_t;

    // Operations requested from the frame store in one cycle.
    typedef struct packed {
        logic clear_all;
        logic set_use;
        logic clear_use;
        logic write_page;
    } store_ctrl_t;

endpackage

/* sv/clock_page_replacement.sv */
// Clock (second chance) page replacement engine: lookup, fill and sweep sequencer.
// Depends on cpr_pkg, cpr_frame_store and clock_page_replacement_macros.svh.
// Steps: accept, a lookup scan of the filled frames; on a fault hand steps that reduce modulo
// the frame count and fill or examine a frame, a victim read on an eviction, and an output load.
// A new page is accepted only once the previous result is loaded into the output register.
// Async reset clears use bits, hand and counters.
`include "clock_page_replacement_macros.svh"

module clock_page_replacement #(
    parameter int FRAMES    = cpr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave side. tdata: page_number[19:0], zero fill [23:20].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cpr_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Master side. tdata: hit[0], victim_valid[1], victim_page[21:2],
    // frame_index[25:22], hits_so_far[57:26], misses_so_far[89:58], zero fill [95:90].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cpr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration write port.
    input  logic                               cfg_we,
    input  cpr_pkg::cfg_reg_t                  cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int STORE_BITS = (PAGE_BITS < cpr_pkg::PAGE_W) ? PAGE_BITS : cpr_pkg::PAGE_W;
    localparam int FIDX       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int PAD_W      = cpr_pkg::OUT_TDATA_W - cpr_pkg::OUT_USED_W;

    cpr_pkg::state_t state_reg, state_next;

    logic [cpr_pkg::FRAME_COUNT_W-1:0] frame_count_reg;
    logic [cpr_pkg::TICK_PERIOD_W-1:0] tick_period_reg;

    logic [STORE_BITS-1:0]             page_reg, page_next;
    logic [CNT_W-1:0]                  issue_reg, issue_next;
    logic                              cmp_valid_reg, cmp_valid_next;
    logic [FIDX-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]                  adv_reg, adv_next;
    logic                              fill_mode_reg, fill_mode_next;
    logic [FIDX-1:0]                   hand_reg, hand_next;
    logic [CNT_W-1:0]                  filled_reg, filled_next;
    logic [cpr_pkg::TICK_PERIOD_W-1:0] phase_reg, phase_next;
    logic [cpr_pkg::COUNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [cpr_pkg::COUNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic                              res_hit_reg, res_hit_next;
    logic                              res_vv_reg, res_vv_next;
    logic [STORE_BITS-1:0]             res_victim_reg, res_victim_next;
    logic [FIDX-1:0]                   res_frame_reg, res_frame_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [cpr_pkg::OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]                  active_frames;
    logic [cpr_pkg::TICK_PERIOD_W-1:0] period;
    logic [cpr_pkg::TICK_PERIOD_W-1:0] phase_inc;
    logic [CNT_W-1:0]                  adv_inc;
    logic [cpr_pkg::COUNT_W-1:0]       hit_new;
    logic [cpr_pkg::COUNT_W-1:0]       miss_new;
    logic                              out_load;

    cpr_pkg::store_ctrl_t              store_ctrl;
    logic [FIDX-1:0]                   rd_addr;
    logic [FIDX-1:0]                   wr_addr;
    logic [FIDX-1:0]                   use_addr;
    logic [STORE_BITS-1:0]             rd_page;
    logic                              use_bit;

    cpr_frame_store #(
        .FRAMES (FRAMES),
        .PAGE_W (STORE_BITS),
        .IDX_W  (FIDX)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (store_ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_page  (page_reg),
        .use_addr (use_addr),
        .rd_page  (rd_page),
        .use_bit  (use_bit)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= cpr_pkg::FRAME_COUNT_RESET;
            tick_period_reg <= cpr_pkg::TICK_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpr_pkg::REG_FRAME_COUNT: frame_count_reg <= cfg_data[cpr_pkg::FRAME_COUNT_W-1:0];
                cpr_pkg::REG_TICK_PERIOD: tick_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame count and tick period after range clamping.
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            active_frames = CNT_W'(1);
        end
        else if (32'(frame_count_reg) > 32'(FRAMES))
        begin
            active_frames = CNT_W'(FRAMES);
        end
        else
        begin
            active_frames = CNT_W'(frame_count_reg);
        end
        period    = (tick_period_reg == '0) ? cpr_pkg::TICK_PERIOD_W'(1) : tick_period_reg;
        phase_inc = phase_reg + cpr_pkg::TICK_PERIOD_W'(1);
        adv_inc   = adv_reg + CNT_W'(1);
        hit_new   = hit_cnt_reg + cpr_pkg::COUNT_W'(res_hit_reg);
        miss_new  = miss_cnt_reg + cpr_pkg::COUNT_W'(!res_hit_reg);
    end

    assign s_tready = (state_reg == cpr_pkg::ST_IDLE);
    assign out_load = (state_reg == cpr_pkg::ST_FINISH) && (!m_tvalid_reg || m_tready);

    // Sequencer: next state, frame store operations and result assembly.
    always_comb
    begin
        state_next      = state_reg;
        page_next       = page_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        adv_next        = adv_reg;
        fill_mode_next  = fill_mode_reg;
        hand_next       = hand_reg;
        filled_next     = filled_reg;
        phase_next      = phase_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        res_hit_next    = res_hit_reg;
        res_vv_next     = res_vv_reg;
        res_victim_next = res_victim_reg;
        res_frame_next  = res_frame_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        store_ctrl      = '0;
        rd_addr         = issue_reg[FIDX-1:0];
        wr_addr         = hand_reg;
        use_addr        = adv_reg[FIDX-1:0];

        // A waiting result leaves once the master side takes it.
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    page_next            = s_tdata[STORE_BITS-1:0];
                    store_ctrl.clear_all = (phase_reg == '0);
                    phase_next           = (phase_inc >= period) ? '0 : phase_inc;
                    issue_next           = '0;
                    cmp_valid_next       = 1'b0;
                    state_next           = cpr_pkg::ST_LOOKUP;
                end
            end

            // Scan filled frames, one read issued and one compare per cycle.
            cpr_pkg::ST_LOOKUP:
            begin
                if (cmp_valid_reg && (rd_page == page_reg))
                begin
                    res_hit_next       = 1'b1;
                    res_vv_next        = 1'b0;
                    res_victim_next    = '0;
                    res_frame_next     = cmp_idx_reg;
                    use_addr           = cmp_idx_reg;
                    store_ctrl.set_use = 1'b1;
                    cmp_valid_next     = 1'b0;
                    state_next         = cpr_pkg::ST_FINISH;
                end
                else if (issue_reg < filled_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[FIDX-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
                else if (cmp_valid_reg)
                begin
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    res_hit_next    = 1'b0;
                    res_vv_next     = 1'b0;
                    res_victim_next = '0;
                    fill_mode_next  = (filled_reg < active_frames);
                    adv_next        = CNT_W'(hand_reg) + CNT_W'(1);
                    state_next      = cpr_pkg::ST_ADVANCE;
                end
            end

            // Hand step: reduce modulo the frame count, then fill or examine the frame.
            cpr_pkg::ST_ADVANCE:
            begin
                if (adv_reg >= active_frames)
                begin
                    adv_next = adv_reg - active_frames;
                end
                else
                begin
                    hand_next = adv_reg[FIDX-1:0];
                    if (fill_mode_reg)
                    begin
                        wr_addr               = filled_reg[FIDX-1:0];
                        use_addr              = filled_reg[FIDX-1:0];
                        store_ctrl.write_page = 1'b1;
                        store_ctrl.set_use    = 1'b1;
                        res_frame_next        = filled_reg[FIDX-1:0];
                        filled_next           = filled_reg + CNT_W'(1);
                        state_next            = cpr_pkg::ST_FINISH;
                    end
                    else if (use_bit)
                    begin
                        store_ctrl.clear_use = 1'b1;
                        adv_next             = (adv_inc == active_frames) ? '0 : adv_inc;
                    end
                    else
                    begin
                        rd_addr        = adv_reg[FIDX-1:0];
                        res_frame_next = adv_reg[FIDX-1:0];
                        state_next     = cpr_pkg::ST_VICTIM;
                    end
                end
            end

            // Victim page is on the read port; replace it with the new page.
            cpr_pkg::ST_VICTIM:
            begin
                res_vv_next           = 1'b1;
                res_victim_next       = rd_page;
                wr_addr               = hand_reg;
                use_addr              = hand_reg;
                store_ctrl.write_page = 1'b1;
                store_ctrl.set_use    = 1'b1;
                state_next            = cpr_pkg::ST_FINISH;
            end

            cpr_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    hit_cnt_next  = hit_new;
                    miss_cnt_next = miss_new;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0), miss_new, hit_new,
                                     cpr_pkg::FRAME_INDEX_W'(res_frame_reg),
                                     cpr_pkg::PAGE_W'(res_victim_reg),
                                     res_vv_reg, res_hit_reg};
                    state_next    = cpr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::ST_IDLE;
            cmp_valid_reg <= 1'b0;
            hand_reg      <= '0;
            filled_reg    <= '0;
            phase_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            hand_reg      <= hand_next;
            filled_reg    <= filled_next;
            phase_reg     <= phase_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        adv_reg        <= adv_next;
        fill_mode_reg  <= fill_mode_next;
        res_hit_reg    <= res_hit_next;
        res_vv_reg     <= res_vv_next;
        res_victim_reg <= res_victim_next;
        res_frame_reg  <= res_frame_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The fill count never passes the number of frames.
    `CPR_ASSERT(a_filled_bound, clk, rst_n, filled_reg <= CNT_W'(FRAMES))
    // A hit never evicts a page.
    `CPR_ASSERT_IMP(a_hit_no_victim, clk, rst_n, m_tvalid_reg, !(m_tdata_reg[0] && m_tdata_reg[1]))
    // Without an eviction the victim page field reads zero.
    `CPR_ASSERT_IMP(a_victim_zero, clk, rst_n, m_tvalid_reg && !m_tdata_reg[1], m_tdata_reg[21:2] == '0)
    // Every delivered result counts exactly one hit or one fault.
    `CPR_ASSERT_IMP(a_count_step, clk, rst_n, out_load,
        ##1 ((hit_cnt_reg + miss_cnt_reg) == ($past(hit_cnt_reg + miss_cnt_reg) + 32'd1)))

endmodule

/* sv/cpr_frame_store.sv */
// Frame store: the resident page memory and the per-frame use bits.
// Depends on cpr_pkg for the store_ctrl_t operation group.
module cpr_frame_store #(
    parameter int FRAMES = cpr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_W = cpr_pkg::PAGE_W,
    parameter int IDX_W  = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpr_pkg::store_ctrl_t ctrl,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [PAGE_W-1:0]    wr_page,
    input  logic [IDX_W-1:0]     use_addr,
    output logic [PAGE_W-1:0]    rd_page,
    output logic                 use_bit
);

    logic [PAGE_W-1:0] page_mem_reg [FRAMES];
    logic [PAGE_W-1:0] rd_page_reg;
    logic [FRAMES-1:0] use_bits_reg;
    logic [FRAMES-1:0] use_bits_next;

    // Page memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.write_page)
        begin
            page_mem_reg[wr_addr] <= wr_page;
        end
        rd_page_reg <= page_mem_reg[rd_addr];
    end

    assign rd_page = rd_page_reg;

    // Use bits: a periodic clear of all frames, or a set or clear of one frame.
    always_comb
    begin
        use_bits_next = use_bits_reg;
        if (ctrl.clear_all)
        begin
            use_bits_next = '0;
        end
        else if (ctrl.set_use)
        begin
            use_bits_next[use_addr] = 1'b1;
        end
        else if (ctrl.clear_use)
        begin
            use_bits_next[use_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_bits_reg <= '0;
        end
        else
        begin
            use_bits_reg <= use_bits_next;
        end
    end

    assign use_bit = use_bits_reg[use_addr];

endmodule
